// File: sv/hpd_pkg.sv
// Shared types, constants and helpers for the Huffman prefix decoder.
package hpd_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 257;

   localparam int CMD_W  = 2;
   localparam int SYM_W  = 9;
   localparam int CODE_W = 32;
   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;

   localparam int PREFIX_W = MAX_CODE_LEN;
   localparam int PLEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int LCMP_W   = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;

   localparam int CELL_ENTRIES = 32;
   localparam int LOCAL_W      = $clog2(CELL_ENTRIES);
   localparam int NUM_CELLS    = (SYMBOL_COUNT + CELL_ENTRIES - 1) / CELL_ENTRIES;
   localparam int CELL_IDX_W   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int IDX_W        = CELL_IDX_W + LOCAL_W;
   localparam int CNT_W        = $clog2(NUM_CELLS + 1);

   localparam int EOF_SYMBOL = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_DECODE = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_BYTE = 2'd0,
      STAT_EOF  = 2'd1,
      STAT_ERR  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } state_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  slot;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
   } load_type;

   typedef struct packed {
      logic [PREFIX_W-1:0] bits;
      logic [PLEN_W-1:0]   length;
   } prefix_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } token_type;

   // Keep only the low len bits of a code; len at or above the width keeps all.
   function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
      return ~({CODE_W{1'b1}} << len);
   endfunction

endpackage

// File: sv/hpd_cell.sv
// One cell of the match chain: a slice of the code table, its comparators and a token stage.
module hpd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hpd_pkg::CELL_IDX_W-1:0] cell_id,
   input  hpd_pkg::load_type           load,
   input  hpd_pkg::prefix_type         prefix,
   input  hpd_pkg::token_type          token_in,
   output hpd_pkg::token_type          token_out
);
   import hpd_pkg::*;

   logic [CODE_W-1:0] code_ff [CELL_ENTRIES];
   logic [LEN_W-1:0]  len_ff  [CELL_ENTRIES];
   token_type         token_ff;
   token_type         token_in_next;

   logic [CELL_ENTRIES-1:0] hit;
   logic                    hit_any;
   logic [LOCAL_W-1:0]      hit_idx;
   logic                    sel;

   assign sel = load.we && (load.slot[IDX_W-1:LOCAL_W] == cell_id);

   always_ff @(posedge clock) begin
      if (sel) begin
         code_ff[load.slot[LOCAL_W-1:0]] <= load.code & low_mask(load.length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CELL_ENTRIES; j++) begin
            len_ff[j] <= '0;
         end
      end else if (sel) begin
         len_ff[load.slot[LOCAL_W-1:0]] <= load.length;
      end
   end

   always_comb begin
      for (int j = 0; j < CELL_ENTRIES; j++) begin
         hit[j] = (len_ff[j] != '0) &&
                  (LCMP_W'(len_ff[j]) == LCMP_W'(prefix.length)) &&
                  (PREFIX_W'(code_ff[j]) == prefix.bits);
      end
   end

   // Lowest slot wins among duplicates.
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int j = CELL_ENTRIES - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_any = 1'b1;
            hit_idx = LOCAL_W'(j);
         end
      end
   end

   // Pass an earlier find unchanged, else offer this cell's own.
   always_comb begin
      if (token_in.found) begin
         token_in_next = token_in;
      end else begin
         token_in_next.found = hit_any;
         token_in_next.idx   = {cell_id, hit_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

// File: sv/huffman_prefix_decoder_core.sv
// Top level of the Huffman prefix decoder: command control, prefix register, cell chain.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  cmd, entry_symbol, entry_code, entry_length, data_bit
//   rsp      out        rsp_valid / rsp_ready  out_byte, status
//
// Load, clear and ignored commands are handled in the idle state. A decode bit holds the
// input until its search of all NUM_CELLS cells ends, as the match token walks one cell
// of the chain per cycle; the result is then taken into the output register.
// Reset clears all entry lengths, the prefix and the end flag; code bits stay unknown.
// A decode that yields a result waits at the end of its search while the output register
// is full; new beats are taken while a finished result sits unread.
module huffman_prefix_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hpd_pkg::CMD_W-1:0]    req_cmd,
   input  logic [hpd_pkg::SYM_W-1:0]    req_entry_symbol,
   input  logic [hpd_pkg::CODE_W-1:0]   req_entry_code,
   input  logic [hpd_pkg::LEN_W-1:0]    req_entry_length,
   input  logic                         req_data_bit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hpd_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [hpd_pkg::STAT_W-1:0]   rsp_status
);
   import hpd_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   prefix_type        prefix_ff, prefix_in;
   logic              ended_ff, ended_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   status_type        status_ff, status_in;

   load_type  load;
   token_type chain [NUM_CELLS+1];
   token_type tail;

   logic accept;
   logic search_done;
   logic overflow;
   logic need_out;
   logic out_busy;
   logic finish;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign tail        = chain[NUM_CELLS];
   assign search_done = (cnt_ff == CNT_W'(NUM_CELLS));
   assign overflow    = (prefix_ff.length >= PLEN_W'(MAX_CODE_LEN));
   assign need_out    = tail.found || overflow;
   assign out_busy    = rsp_valid_ff && !rsp_ready;
   assign finish      = (state_ff == S_SEARCH) && search_done && !(need_out && out_busy);

   assign load.we     = accept && (req_cmd == CMD_LOAD) &&
                        (32'(req_entry_symbol) < 32'(SYMBOL_COUNT));
   assign load.slot   = IDX_W'(req_entry_symbol);
   assign load.code   = req_entry_code;
   assign load.length = req_entry_length;

   assign chain[0] = '0;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      hpd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CELL_IDX_W'(c)),
         .load      (load),
         .prefix    (prefix_ff),
         .token_in  (chain[c]),
         .token_out (chain[c+1])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CMD_DECODE) && !ended_ff) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and output register.
   always_comb begin
      cnt_in       = cnt_ff;
      prefix_in    = prefix_ff;
      ended_in     = ended_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      status_in    = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     prefix_in = '0;
                     ended_in  = 1'b0;
                  end
                  CMD_DECODE: begin
                     if (!ended_ff) begin
                        prefix_in.bits   = (prefix_ff.bits << 1) | PREFIX_W'(req_data_bit);
                        prefix_in.length = prefix_ff.length + 1'b1;
                        cnt_in           = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            if (!search_done) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (finish && need_out) begin
               prefix_in    = '0;
               rsp_valid_in = 1'b1;
               if (tail.found && (tail.idx == IDX_W'(EOF_SYMBOL))) begin
                  ended_in  = 1'b1;
                  byte_in   = '0;
                  status_in = STAT_EOF;
               end else if (tail.found) begin
                  byte_in   = tail.idx[BYTE_W-1:0];
                  status_in = STAT_BYTE;
               end else begin
                  byte_in   = '0;
                  status_in = STAT_ERR;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         prefix_ff    <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         prefix_ff    <= prefix_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;

endmodule

// File: verif/huffman_prefix_decoder_core_tb.sv
// Self-checking testbench for the bit-serial Huffman prefix decoder core.
module huffman_prefix_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hpd_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * (NUM_CELLS + 1) + 4;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int SESSION_ITEMS = 150;
   localparam int LONG_HOLD     = 400;
   localparam int SHALLOW_DEPTH = 10;

   typedef enum logic [1:0] {USE_MODEL, WANT_NONE, WANT_RESULT} row_chk_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SYM_W-1:0]  sym;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              dbit;
      row_chk_type       chk;
      logic [BYTE_W-1:0] xbyte;
      logic [STAT_W-1:0] xstat;
   } script_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [STAT_W-1:0] status;
   } decoded_type;

   localparam script_row_type SCRIPT [25] = '{
      '{CMD_CLEAR,  9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_UNUSED, 9'h1FF, 32'hFFFF_FFFF, 6'h3F, 1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      // stored as the one-bit code 0
      '{CMD_LOAD,   9'h041, 32'hFFFF_FFFE, 6'd1,  1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_LOAD,   SYM_W'(EOF_SYMBOL), 32'hFFFF_FFFF, 6'd2, 1'b0, WANT_NONE, 8'h00,
        STAT_BYTE},
      // beyond the table: must not land anywhere
      '{CMD_LOAD,   9'h1FF, 32'h0000_0002, 6'd2,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_RESULT, 8'h41, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_CLEAR,  9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_LOAD,   9'h0FF, 32'h0000_0002, 6'd2,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_RESULT, 8'hFF, STAT_BYTE},
      // same code at a lower index takes over
      '{CMD_LOAD,   9'h000, 32'hFFFF_FFFE, 6'd2,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_RESULT, 8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, WANT_RESULT, 8'h00, STAT_EOF},
      // stream has ended: bits are dropped
      '{CMD_DECODE, 9'h1FF, 32'hFFFF_FFFF, 6'h3F, 1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_CLEAR,  9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_LOAD,   9'h003, 32'h0000_0000, 6'h3F, 1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_LOAD,   9'h041, 32'hFFFF_FFFF, 6'd0,  1'b0, WANT_NONE,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b0, USE_MODEL,   8'h00, STAT_BYTE},
      '{CMD_DECODE, 9'h000, 32'h0000_0000, 6'd0,  1'b1, USE_MODEL,   8'h00, STAT_BYTE},
      '{CMD_CLEAR,  9'h000, 32'h0000_0000, 6'd0,  1'b0, WANT_NONE,   8'h00, STAT_BYTE}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd;
   logic [SYM_W-1:0]  req_entry_symbol;
   logic [CODE_W-1:0] req_entry_code;
   logic [LEN_W-1:0]  req_entry_length;
   logic              req_data_bit;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic [STAT_W-1:0] rsp_status;

   huffman_prefix_decoder_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decoder image
   logic [CODE_W-1:0]   tbl_code [SYMBOL_COUNT];
   logic [LEN_W-1:0]    tbl_len  [SYMBOL_COUNT];
   logic [PREFIX_W-1:0] pfx_bits;
   int                  pfx_len;
   logic                stream_ended;

   decoded_type expected_symbols [$];
   int mismatch_count = 0;
   int work_items     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asks      = 0;

   // prefix code tree of the current session
   logic [CODE_W-1:0] leaf_code [$];
   int                leaf_len  [$];
   int                leaf_sym  [$];

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic bit walk_prefix(input logic [CMD_W-1:0] cmd,
                                      input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0] len,
                                      input logic dbit,
                                      output decoded_type res);
      logic [63:0] keep;
      int hit;
      res = '{out_byte: '0, status: STAT_BYTE};
      hit = -1;
      keep = (len >= CODE_W) ? '1 : ((64'd1 << len) - 64'd1);
      case (cmd)
         CMD_LOAD: begin
            if (sym < SYMBOL_COUNT) begin
               tbl_code[sym] = code & keep[CODE_W-1:0];
               tbl_len[sym]  = len;
            end
            return 1'b0;
         end
         CMD_CLEAR: begin
            pfx_bits = '0;
            pfx_len = 0;
            stream_ended = 1'b0;
            return 1'b0;
         end
         CMD_DECODE: ;
         default: return 1'b0;
      endcase
      if (stream_ended)
         return 1'b0;
      pfx_bits = {pfx_bits[PREFIX_W-2:0], dbit};
      pfx_len++;
      for (int i = 0; i < SYMBOL_COUNT && hit < 0; i++)
         if (tbl_len[i] != 0 && tbl_len[i] == pfx_len && tbl_code[i] == pfx_bits)
            hit = i;
      if (hit >= 0) begin
         pfx_bits = '0;
         pfx_len = 0;
         if (hit == EOF_SYMBOL) begin
            stream_ended = 1'b1;
            res.status = STAT_EOF;
         end else begin
            res.out_byte = hit[BYTE_W-1:0];
         end
         return 1'b1;
      end
      if (pfx_len >= MAX_CODE_LEN) begin
         pfx_bits = '0;
         pfx_len = 0;
         res.status = STAT_ERR;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                            input logic dbit, input row_chk_type chk = USE_MODEL,
                            input logic [BYTE_W-1:0] xbyte = '0,
                            input logic [STAT_W-1:0] xstat = '0);
      decoded_type res;
      bit got;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_entry_symbol <= sym;
      req_entry_code   <= code;
      req_entry_length <= len;
      req_data_bit     <= dbit;
      do @(posedge clock); while (!req_ready);
      if (cmd != CMD_UNUSED && !(cmd == CMD_DECODE && stream_ended) &&
          !(cmd == CMD_LOAD && sym >= SYMBOL_COUNT))
         work_items++;
      got = walk_prefix(cmd, sym, code, len, dbit, res);
      case (chk)
         USE_MODEL:   if (got) expected_symbols.push_back(res);
         WANT_RESULT: expected_symbols.push_back('{out_byte: xbyte, status: xstat});
         default: ;
      endcase
   endtask

   task automatic send_decode(input logic dbit);
      push_beat(CMD_DECODE, SYM_W'($urandom), $urandom, LEN_W'($urandom), dbit);
   endtask

   task automatic send_clear();
      push_beat(CMD_CLEAR, SYM_W'($urandom), $urandom, LEN_W'($urandom), 1'($urandom));
   endtask

   task automatic send_load(input int sym, input logic [CODE_W-1:0] code, input int len);
      logic [63:0] junk;
      // garbage above the code length must be dropped by the block
      junk = {$urandom, $urandom} << len;
      push_beat(CMD_LOAD, SYM_W'(sym), code | junk[CODE_W-1:0], LEN_W'(len),
                1'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_symbols.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void split_leaf(input int k);
      leaf_code.push_back({leaf_code[k][CODE_W-2:0], 1'b1});
      leaf_len.push_back(leaf_len[k] + 1);
      leaf_code[k] = {leaf_code[k][CODE_W-2:0], 1'b0};
      leaf_len[k]++;
   endfunction

   task automatic run_session(input int sidx);
      int n, i, j, k, base, guard, eof_leaf, stop_at;
      int pool [$];
      bit deep, holes;
      case (sidx % 4)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
         default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (sidx % 2 == 1)
         drain_results();
      stop_at = work_items + SESSION_ITEMS;

      // retire whatever the last table left behind
      for (i = 0; i < SYMBOL_COUNT; i++)
         if (tbl_len[i] != 0)
            send_load(i, '0, 0);
      send_clear();

      // grow a complete prefix code by splitting leaves
      deep  = (sidx % 3 == 1);
      holes = (sidx % 2 == 0);
      leaf_code.delete();
      leaf_len.delete();
      leaf_code.push_back('0);
      leaf_len.push_back(0);
      if (deep) begin
         k = 0;
         repeat (MAX_CODE_LEN) begin
            split_leaf(k);
            if ($urandom_range(1) == 1)
               k = leaf_code.size() - 1;
         end
      end
      n = leaf_code.size() + $urandom_range(20, 1);
      guard = 0;
      while (leaf_code.size() < n && guard < 1000) begin
         k = $urandom_range(leaf_code.size() - 1);
         if (leaf_len[k] < SHALLOW_DEPTH)
            split_leaf(k);
         guard++;
      end

      pool.delete();
      for (i = 0; i < (1 << BYTE_W); i++)
         pool.push_back(i);
      eof_leaf = (sidx % 5 == 4) ? -1 : int'($urandom_range(leaf_code.size() - 1));
      leaf_sym.delete();
      for (i = 0; i < leaf_code.size(); i++) begin
         if (i == eof_leaf)
            leaf_sym.push_back(EOF_SYMBOL);
         else if (holes && $urandom_range(99) < 8)
            leaf_sym.push_back(-1);
         else begin
            k = $urandom_range(pool.size() - 1);
            leaf_sym.push_back(pool[k]);
            pool.delete(k);
         end
      end

      base = $urandom_range(leaf_code.size() - 1);
      for (i = 0; i < leaf_code.size(); i++) begin
         k = (i + base) % leaf_code.size();
         if (leaf_sym[k] >= 0)
            send_load(leaf_sym[k], leaf_code[k], leaf_len[k]);
      end
      if (sidx == 2)
         hold_asks++;

      while (work_items < stop_at) begin
         if ($urandom_range(99) < 8) begin
            case ($urandom_range(4))
               0: push_beat(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom),
                            1'($urandom));
               1: send_clear();
               2: send_load($urandom_range(SYMBOL_COUNT, (1 << SYM_W) - 1), $urandom,
                            $urandom_range(63));
               3: begin
                  // alias a live code under another symbol
                  j = $urandom_range(leaf_code.size() - 1);
                  send_load($urandom_range(255), leaf_code[j], leaf_len[j]);
               end
               default: send_decode(1'($urandom));
            endcase
         end
         k = $urandom_range(leaf_code.size() - 1);
         for (i = leaf_len[k] - 1; i >= 0; i--)
            send_decode(leaf_code[k][i]);
         if (leaf_sym[k] == EOF_SYMBOL) begin
            repeat ($urandom_range(3)) send_decode(1'($urandom));
            send_clear();
         end else if (leaf_sym[k] < 0) begin
            // nothing lives below a hole: run the prefix into overflow
            repeat (MAX_CODE_LEN - leaf_len[k]) send_decode(1'($urandom));
         end
      end
   endtask

   // result side
   initial begin
      decoded_type want;
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat: byte %02h status %0d",
                                       rsp_out_byte, rsp_status));
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_out_byte !== want.out_byte)
                  flag_mismatch($sformatf("byte %02h, want %02h", rsp_out_byte,
                                          want.out_byte));
            end
         end
         if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (reset || hold_left > 0) begin
            rsp_ready <= 1'b0;
            if (hold_left > 0)
               hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // request side
   initial begin
      script_row_type row;
      int sidx;
      int first;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_CLEAR;
      req_entry_symbol <= '0;
      req_entry_code   <= '0;
      req_entry_length <= '0;
      req_data_bit     <= 1'b0;
      for (int s = 0; s < SYMBOL_COUNT; s++) begin
         tbl_code[s] = '0;
         tbl_len[s]  = '0;
      end
      pfx_bits = '0;
      pfx_len = 0;
      stream_ended = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(SCRIPT); r++) begin
         row = SCRIPT[r];
         push_beat(row.cmd, row.sym, row.code, row.len, row.dbit, row.chk, row.xbyte,
                   row.xstat);
      end

      sidx = 0;
      first = work_items;
      while (sidx < 4 || work_items - first < RANDOM_ITEMS) begin
         run_session(sidx);
         sidx++;
      end

      recv_stall_pct = 0;
      drain_results();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
